### rtl/lfps_pkg.sv
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared widths and types for the table-based fixed-point square root.
// ----------------------------------------------------------------------------
package lfps_pkg;

    // Width of the integer radicand and of the fixed-point root.
    localparam int RAD_W  = 32;
    localparam int ROOT_W = 32;

    // The significant width b runs from 1 to 33 and needs six bits.
    localparam int SIGW_W = 6;

    // Control that travels alongside the table address down the pipeline.
    typedef struct packed {
        logic              valid;
        logic              zero;
        logic [SIGW_W-1:0] sig_width;
    } lfps_ctl_t;

endpackage

### rtl/lfps_norm.sv
// ----------------------------------------------------------------------------
// lfps_norm
// Two-stage normaliser: counts leading zeros and forms the odd significant
// width, then shifts the radicand to a table index and a ROM address.
// ----------------------------------------------------------------------------
module lfps_norm
    import lfps_pkg::*;
#(
    parameter int TABLE_INDEX_BITS = 12
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [RAD_W-1:0]            radicand,
    output lfps_ctl_t                   ctl,
    output logic [TABLE_INDEX_BITS-1:0] rom_addr
);

    localparam logic [SIGW_W-1:0]           TIB  = SIGW_W'(TABLE_INDEX_BITS);
    localparam logic [TABLE_INDEX_BITS-1:0] BASE =
        TABLE_INDEX_BITS'(1) << (TABLE_INDEX_BITS - 2);

    logic              s1_valid_reg;
    logic [RAD_W-1:0]  s1_rad_reg;
    logic [4:0]        lead_zeros;
    logic [SIGW_W-1:0] sig_width_next;

    logic              s2_valid_reg;
    logic              s2_zero_reg;
    logic [RAD_W-1:0]  s2_rad_reg;
    logic [SIGW_W-1:0] s2_width_reg;
    logic [RAD_W-1:0]  shifted;
    logic [TABLE_INDEX_BITS-1:0] index_k;

    // Stage one capture of the incoming item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s1_rad_reg <= radicand;
        end
    end

    // Leading-zero count, capped at 31; the highest set bit wins.
    always_comb
    begin
        lead_zeros = 5'd31;
        for (int i = 0; i < RAD_W; i++)
        begin
            if (s1_rad_reg[i])
            begin
                lead_zeros = 5'(RAD_W - 1 - i);
            end
        end
    end

    // Round the count down to odd, giving an odd significant width.
    always_comb
    begin
        if (lead_zeros[0])
        begin
            sig_width_next = SIGW_W'(32) - SIGW_W'(lead_zeros);
        end
        else
        begin
            sig_width_next = SIGW_W'(33) - SIGW_W'(lead_zeros);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_rad_reg   <= s1_rad_reg;
        s2_width_reg <= sig_width_next;
        s2_zero_reg  <= (s1_rad_reg == '0);
    end

    // Shift the significant bits into a table index of fixed width.
    always_comb
    begin
        if (s2_width_reg > TIB)
        begin
            shifted = s2_rad_reg >> (s2_width_reg - TIB);
        end
        else
        begin
            shifted = s2_rad_reg << (TIB - s2_width_reg);
        end
        index_k = shifted[TABLE_INDEX_BITS-1:0];
    end

    // The table starts at the lowest normalised index; zero has no entry.
    always_comb
    begin
        if (s2_zero_reg)
        begin
            rom_addr = '0;
        end
        else
        begin
            rom_addr = index_k - BASE;
        end
        ctl.valid     = s2_valid_reg;
        ctl.zero      = s2_zero_reg;
        ctl.sig_width = s2_width_reg;
    end

endmodule

### rtl/lfps_rom.sv
// ----------------------------------------------------------------------------
// lfps_rom
// Constant root table with a registered read port. Entry i holds
// floor(sqrt((i + 2^(T-2)) * 2^(2F - T + 1))).
// ----------------------------------------------------------------------------
module lfps_rom
    import lfps_pkg::*;
#(
    parameter int TABLE_INDEX_BITS   = 12,
    parameter int ROOT_FRACTION_BITS = 16
)
(
    input  logic                          clk,
    input  logic [TABLE_INDEX_BITS-1:0]   rd_addr,
    output logic [ROOT_FRACTION_BITS:0]   rd_data
);

    localparam int BASE   = 1 << (TABLE_INDEX_BITS - 2);
    localparam int DEPTH  = 3 * BASE;
    localparam int ENTRY_W = ROOT_FRACTION_BITS + 1;
    localparam int PRE_SHIFT = 2 * ROOT_FRACTION_BITS - TABLE_INDEX_BITS + 1;

    typedef logic [ENTRY_W-1:0] rom_t [DEPTH];

    // Bitwise integer square root, evaluated only while building the table.
    function automatic logic [63:0] isqrt64(input logic [63:0] value);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bit_w;
        v     = value;
        r     = '0;
        bit_w = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= r + bit_w)
            begin
                v = v - (r + bit_w);
                r = (r >> 1) + bit_w;
            end
            else
            begin
                r = r >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return r;
    endfunction

    function automatic rom_t build_rom();
        rom_t        tbl;
        logic [63:0] root_w;
        for (int i = 0; i < DEPTH; i++)
        begin
            root_w = isqrt64(64'(i + BASE) << PRE_SHIFT);
            tbl[i] = root_w[ENTRY_W-1:0];
        end
        return tbl;
    endfunction

    localparam rom_t ROM_DATA = build_rom();

    logic [ENTRY_W-1:0] rd_data_reg;

    // Synchronous read; the table entry is registered.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= ROM_DATA[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/lut_fixed_point_sqrt.sv
// ----------------------------------------------------------------------------
// lut_fixed_point_sqrt
// Square root of an unsigned 32-bit integer in unsigned Q16.16, read from a
// normalised lookup table without interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a radicand; the item is taken at any edge where start is
//   high and busy is low. busy stays low, so one item can enter every cycle.
//   Each result appears on root for exactly one cycle with done high. The
//   receiver cannot hold results off and must take every one.
// Pipeline and throughput:
//   An accepted item passes the leading-zero count, the normalising shift,
//   the table read and the final scaling shift, in that order.
//   One item per cycle sustained; the single read port of the root table
//   serves one lookup each cycle and sets that rate.
// Reset:
//   rst_n clears all valid flags at once; items in flight are dropped. The
//   table is constant, so no clearing pass is needed and start is taken in
//   the first cycle after reset.
// A zero radicand returns zero; every other value returns a non-zero root.
// ----------------------------------------------------------------------------
module lut_fixed_point_sqrt
    import lfps_pkg::*;
#(
    parameter int TABLE_INDEX_BITS   = 12,
    parameter int ROOT_FRACTION_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int ENTRY_W = ROOT_FRACTION_BITS + 1;

    lfps_ctl_t                   norm_ctl;
    logic [TABLE_INDEX_BITS-1:0] rom_addr;
    logic [ENTRY_W-1:0]          rom_data;
    lfps_ctl_t                   s3_ctl_reg;
    logic [63:0]                 scaled;
    logic [ROOT_W-1:0]           root_next;
    logic                        done_reg;
    logic [ROOT_W-1:0]           root_reg;
    logic                        accept;

    // The pipeline never stalls, so an item is taken whenever start is high.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    lfps_norm #(
        .TABLE_INDEX_BITS (TABLE_INDEX_BITS)
    ) u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .radicand (radicand),
        .ctl      (norm_ctl),
        .rom_addr (rom_addr)
    );

    lfps_rom #(
        .TABLE_INDEX_BITS   (TABLE_INDEX_BITS),
        .ROOT_FRACTION_BITS (ROOT_FRACTION_BITS)
    ) u_rom (
        .clk     (clk),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    // Control travels beside the table read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctl_reg <= '0;
        end
        else
        begin
            s3_ctl_reg <= norm_ctl;
        end
    end

    // Scale the table entry by 2^((b-1)/2), b being odd, and keep the low 32 bits; a zero radicand gives zero.
    always_comb
    begin
        scaled = 64'(rom_data) << (s3_ctl_reg.sig_width >> 1);
        if (s3_ctl_reg.zero)
        begin
            root_next = '0;
        end
        else
        begin
            root_next = scaled[ROOT_W-1:0];
        end
    end

    // Output register and strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s3_ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### rtl/lfps_checker.sv
// ----------------------------------------------------------------------------
// lfps_checker
// Port-level checks on the square root block: fixed latency, one result per
// item and the zero and non-zero cases of the root.
// ----------------------------------------------------------------------------
module lfps_checker
    import lfps_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic [RAD_W-1:0]  radicand,
    input logic              done,
    input logic [ROOT_W-1:0] root
);

    // Every accepted item yields a result strobe on done.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("result missing four cycles after an accepted item");

    // No result appears without a matching accepted item.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result strobe without a matching item");

    // A zero radicand gives a zero root.
    a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (radicand == '0)) |-> ##4 (root == '0))
        else $error("zero radicand did not give a zero root");

    // Any non-zero radicand gives a non-zero root.
    a_nonzero_root: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (radicand != '0)) |-> ##4 (root != '0))
        else $error("non-zero radicand gave a zero root");

endmodule

bind lut_fixed_point_sqrt lfps_checker u_lfps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .radicand (radicand),
    .done     (done),
    .root     (root)
);
